/* src/b64u_pkg.sv */
// Shared types and constants for the URL-safe base64 decoder.
package b64u_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [7:0]  PAD_RESET   = 8'h21;

	// One run: the results caused by one accepted character.
	typedef struct packed {
		logic [23:0] bytes;     // first result in the top byte
		logic [1:0]  last_idx;  // index of the final result of the run
		logic        has_bytes; // 0 for a bare end mark
		logic        done;      // the run closes the message
	} run_t;

endpackage

/* src/b64u_front.sv */
// Front end: accepts characters, maps them to sextets and builds result runs.
module b64u_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [7:0]        cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        char_byte,
	input  logic              message_end,
	input  logic              q_full,
	output logic              q_push,
	output b64u_pkg::run_t    q_data
);
	import b64u_pkg::*;

	logic [7:0]  pad_q;
	logic [17:0] buf_q;
	logic [1:0]  cnt_q;
	logic        stopped_q;

	logic        accept;
	logic        sx_ok;
	logic [5:0]  sx;
	logic        char_ok;
	logic [17:0] buf_a;
	logic [1:0]  cnt_a;
	logic        stop_a;
	logic        grp;
	logic        do_flush;
	logic [17:0] fbuf;
	logic [1:0]  fcnt;
	run_t        run;

	always_comb begin
		sx_ok = 1'b1;
		sx    = 6'd0;
		if (char_byte inside {[8'h41:8'h5A]}) begin
			sx = 6'(char_byte - 8'h41);
		end else if (char_byte inside {[8'h61:8'h7A]}) begin
			sx = 6'(char_byte - 8'h61 + 8'd26);
		end else if (char_byte inside {[8'h30:8'h39]}) begin
			sx = 6'(char_byte - 8'h30 + 8'd52);
		end else if (char_byte == 8'h5F) begin
			sx = 6'd62;
		end else if (char_byte == 8'h2D) begin
			sx = 6'd63;
		end else begin
			sx_ok = 1'b0;
		end
	end

	// The pad test wins over the alphabet.
	assign char_ok = sx_ok && (char_byte != pad_q);

	always_comb begin
		buf_a    = buf_q;
		cnt_a    = cnt_q;
		stop_a   = stopped_q;
		grp      = 1'b0;
		do_flush = 1'b0;
		fbuf     = buf_q;
		fcnt     = cnt_q;
		if (!stopped_q) begin
			if (!char_ok) begin
				stop_a   = 1'b1;
				do_flush = 1'b1;
				buf_a    = '0;
				cnt_a    = '0;
			end else if (cnt_q == 2'd3) begin
				grp   = 1'b1;
				buf_a = '0;
				cnt_a = '0;
			end else begin
				buf_a = {buf_q[11:0], sx};
				cnt_a = cnt_q + 2'd1;
			end
		end
		// An end character flushes what is still pending after its own sextet.
		if (message_end && !stop_a) begin
			do_flush = 1'b1;
			fbuf     = buf_a;
			fcnt     = cnt_a;
		end
	end

	always_comb begin
		run.bytes     = '0;
		run.last_idx  = 2'd0;
		run.has_bytes = 1'b0;
		run.done      = message_end;
		if (grp) begin
			run.bytes     = {buf_q, sx};
			run.last_idx  = 2'd2;
			run.has_bytes = 1'b1;
		end else if (do_flush && fcnt == 2'd3) begin
			run.bytes     = {fbuf[17:10], fbuf[9:2], 8'd0};
			run.last_idx  = 2'd1;
			run.has_bytes = 1'b1;
		end else if (do_flush && fcnt == 2'd2) begin
			run.bytes     = {fbuf[11:4], 16'd0};
			run.has_bytes = 1'b1;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (run.has_bytes || message_end);
	assign q_data   = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q     <= PAD_RESET;
			buf_q     <= '0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pad_q <= cfg_wr_data;
			end
			if (accept) begin
				if (message_end) begin
					buf_q     <= '0;
					cnt_q     <= '0;
					stopped_q <= 1'b0;
				end else begin
					buf_q     <= buf_a;
					cnt_q     <= cnt_a;
					stopped_q <= stop_a;
				end
			end
		end
	end

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (cnt_q == 2'd0 && buf_q == 18'd0))
		else $error("pending sextets held after a stop");

endmodule

/* src/b64u_queue.sv */
// Small register queue of result runs between the front and back ends.
module b64u_queue #(
	parameter int unsigned DEPTH = b64u_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64u_pkg::run_t wr_data,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output b64u_pkg::run_t rd_data
);
	import b64u_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	run_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full) |-> pop)
		else $error("run pushed into a full queue");

endmodule

/* src/b64u_back.sv */
// Back end: takes runs from the queue and presents their results one beat each.
module b64u_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  b64u_pkg::run_t q_data,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     data_byte,
	output logic           byte_valid,
	output logic           message_done,
	output logic           last_of_run
);
	import b64u_pkg::*;

	run_t       cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       last;

	assign last  = (idx_q == cur_q.last_idx);
	assign q_pop = q_valid && (!cur_valid_q || (out_ready && last));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (cur_valid_q && out_ready) begin
				if (last) begin
					cur_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_comb begin
		case (idx_q)
			2'd0:    data_byte = cur_q.bytes[23:16];
			2'd1:    data_byte = cur_q.bytes[15:8];
			default: data_byte = cur_q.bytes[7:0];
		endcase
	end

	assign out_valid    = cur_valid_q;
	assign byte_valid   = cur_q.has_bytes;
	assign last_of_run  = last;
	assign message_done = cur_q.done && last;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && message_done) |-> last_of_run)
		else $error("end mark not on the last beat of its run");

	a_bare_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !byte_valid) |-> (message_done && data_byte == 8'd0))
		else $error("empty beat that is not a bare end mark");

endmodule

/* src/base64_url_decoder_unit.sv */
// Top level of the URL-safe base64 decoder: front end, run queue and back end.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  config  | cfg_wr_en, cfg_wr_data                          | in
//  input   | in_valid, in_ready, char_byte, message_end      | in
//  output  | out_valid, out_ready, data_byte, byte_valid,    | out
//          | message_done, last_of_run                       |
//
// One character beat is taken per cycle while the run queue has room; the first
// result beat that it causes is registered in the run queue and then in the
// back end before it is offered. The back end gives one result beat per cycle
// while out_ready is high, so a group of four characters yields three beats.
// Reset clears the pending sextets, the stop flag and the queue; pad is 0x21.
// A stalled output fills the run queue and then holds the input.
module base64_url_decoder_unit #(
	parameter int unsigned QDEPTH = b64u_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       message_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       message_done,
	output logic       last_of_run
);
	import b64u_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	run_t q_wr;
	run_t q_rd;

	b64u_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_byte   (char_byte),
		.message_end (message_end),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wr)
	);

	b64u_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.rd_data (q_rd)
	);

	b64u_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_rd),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.message_done (message_done),
		.last_of_run  (last_of_run)
	);

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the URL-safe base64 decoder unit.
module tb_top;
	import b64u_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} char_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       done;
		logic       last;
	} result_beat_t;

	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int PHASE_ITEMS  = 45;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] char_byte   = 8'h00;
	logic       message_end = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_done;
	logic       last_of_run;

	char_beat_t   char_q[$];
	result_beat_t expected_bytes[$];

	// Shadow copy of the decoder state.
	logic [17:0] pend_buf = '0;
	logic [1:0]  pend_cnt = '0;
	logic        halted   = 1'b0;
	logic [7:0]  pad_reg  = PAD_RESET;

	logic in_taken = 1'b0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   error_cnt      = 0;
	int   chars_taken    = 0;
	int   beats_checked  = 0;
	int   chars_queued   = 0;
	int   pad_writes     = 0;
	int   cycle_cnt      = 0;

	base64_url_decoder_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.data_byte    (data_byte),
		.byte_valid   (byte_valid),
		.message_done (message_done),
		.last_of_run  (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("ERROR @%0d: %s", cycle_cnt, msg);
		error_cnt++;
	endtask

	// Works out the result beats that one accepted character causes.
	task automatic decode_beat(input logic [7:0] c, input logic fin);
		result_beat_t run [3];
		int           n;
		int           s;
		logic         flush;
		logic [23:0]  grp;
		n = 0;
		flush = 1'b0;
		// The pad test wins over the alphabet, so a pad letter still stops.
		if (c == pad_reg)
			s = -1;
		else if (c >= "A" && c <= "Z")
			s = c - "A";
		else if (c >= "a" && c <= "z")
			s = c - "a" + 26;
		else if (c >= "0" && c <= "9")
			s = c - "0" + 52;
		else if (c == "_")
			s = 62;
		else if (c == "-")
			s = 63;
		else
			s = -1;
		if (!halted) begin
			if (s < 0) begin
				halted = 1'b1;
				flush = 1'b1;
			end else if (pend_cnt == 2'd3) begin
				grp = {pend_buf, 6'(s)};
				run[0] = '{grp[23:16], 1'b1, 1'b0, 1'b0};
				run[1] = '{grp[15:8], 1'b1, 1'b0, 1'b0};
				run[2] = '{grp[7:0], 1'b1, 1'b0, 1'b0};
				n = 3;
				pend_buf = '0;
				pend_cnt = '0;
			end else begin
				pend_buf = {pend_buf[11:0], 6'(s)};
				pend_cnt = pend_cnt + 2'd1;
			end
		end
		if (fin && !halted)
			flush = 1'b1;
		if (flush) begin
			if (pend_cnt == 2'd2) begin
				run[n] = '{pend_buf[11:4], 1'b1, 1'b0, 1'b0};
				n++;
			end else if (pend_cnt == 2'd3) begin
				run[n] = '{pend_buf[17:10], 1'b1, 1'b0, 1'b0};
				run[n + 1] = '{pend_buf[9:2], 1'b1, 1'b0, 1'b0};
				n += 2;
			end
			pend_buf = '0;
			pend_cnt = '0;
		end
		if (fin) begin
			if (n == 0) begin
				run[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
				n = 1;
			end
			run[n - 1].done = 1'b1;
			pend_buf = '0;
			pend_cnt = '0;
			halted = 1'b0;
		end
		if (n > 0)
			run[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_bytes.push_back(run[i]);
	endtask

	function automatic logic [7:0] b64_char(input logic [5:0] s);
		if (s < 26)
			return 8'("A" + s);
		else if (s < 52)
			return 8'("a" + s - 26);
		else if (s < 62)
			return 8'("0" + s - 52);
		else if (s == 62)
			return "_";
		return "-";
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		char_q.push_back('{c, fin});
		chars_queued++;
	endtask

	task automatic send_msg(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// Mostly well-formed messages with random content; some noise and cut-off tails.
	task automatic send_random_message();
		char_beat_t msg[$];
		int         body;
		int         kind;
		int         extra;
		logic [7:0] bad;
		kind = $urandom_range(9);
		if (kind == 0) begin
			body = $urandom_range(1, 10);
			for (int i = 0; i < body; i++)
				msg.push_back('{8'($urandom_range(255)), 1'($urandom_range(5) == 0)});
		end else begin
			body = $urandom_range(0, 10);
			for (int i = 0; i < body; i++)
				msg.push_back('{b64_char(6'($urandom_range(63))), 1'b0});
			extra = $urandom_range(0, 3);
			case ($urandom_range(3))
				1: begin
					msg.push_back('{pad_reg, 1'b0});
					if ($urandom_range(1))
						msg.push_back('{pad_reg, 1'b0});
				end
				2: begin
					bad = $urandom_range(1) ? 8'($urandom_range(128, 255)) : "=";
					msg.push_back('{bad, 1'b0});
					for (int i = 0; i < extra; i++)
						msg.push_back('{b64_char(6'($urandom_range(63))), 1'b0});
				end
				3: begin
					msg.push_back('{pad_reg, 1'b0});
					for (int i = 0; i < extra; i++)
						msg.push_back('{b64_char(6'($urandom_range(63))), 1'b0});
				end
				default: ;
			endcase
			if (msg.size() == 0)
				msg.push_back('{b64_char(6'($urandom_range(63))), 1'b0});
		end
		msg[msg.size() - 1].fin = 1'b1;
		foreach (msg[i])
			send_char(msg[i].ch, msg[i].fin);
	endtask

	// Waits until every queued character is taken and every result has come out.
	task automatic wait_drained();
		while (char_q.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		// Characters that cause no result may still be in flight.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_pad(input logic [7:0] v);
		wait_drained();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		pad_reg = v;
		pad_writes++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					char_byte <= char_q[0].ch;
					message_end <= char_q[0].fin;
					void'(char_q.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		result_beat_t want;
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				decode_beat(char_byte, message_end);
				chars_taken++;
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					report_error($sformatf("unexpected result beat, data_byte %h", data_byte));
				end else begin
					want = expected_bytes.pop_front();
					beats_checked++;
					if (data_byte !== want.data)
						report_error($sformatf("data_byte %h, expected %h",
							data_byte, want.data));
					if (byte_valid !== want.has_byte)
						report_error($sformatf("byte_valid %b, expected %b",
							byte_valid, want.has_byte));
					if (message_done !== want.done)
						report_error($sformatf("message_done %b, expected %b",
							message_done, want.done));
					if (last_of_run !== want.last)
						report_error($sformatf("last_of_run %b, expected %b",
							last_of_run, want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("base64_url_decoder_unit verification failed");
			$finish;
		end
	end

	initial begin
		int start;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed part under the reset pad character.
		send_msg("TWFu");
		send_msg("TQ");
		send_msg("TWE");
		send_msg("T");
		send_msg("_-!AA");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
		send_msg("zZ09");

		// A pad character that is also a letter of the alphabet.
		write_pad("A");
		send_msg("BBA");

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_pad(8'hFF);
				1: write_pad(8'h00);
				2: write_pad("=");
				default: write_pad(8'($urandom_range(255)));
			endcase
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 23) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 76 : 23) : 0;
			start = chars_queued;
			while (chars_queued - start < PHASE_ITEMS) begin
				send_random_message();
				// In the second phase, hold the sender mid-phase until the output side has emptied.
				if (ph == 1 && chars_queued - start >= PHASE_ITEMS / 2 &&
						chars_queued - start < PHASE_ITEMS / 2 + 12)
					wait_drained();
			end
		end

		wait_drained();
		$display("Decoded %0d characters into %0d checked result beats across %0d pad settings,",
			chars_taken, beats_checked, pad_writes + 1);
		$display("with sender gaps and receiver stalls mixed in four phases.");
		if (error_cnt == 0)
			$display("base64_url_decoder_unit verification clean");
		else
			$display("base64_url_decoder_unit verification failed");
		$finish;
	end

endmodule

/* sim.f */
src/b64u_pkg.sv
src/b64u_front.sv
src/b64u_queue.sv
src/b64u_back.sv
src/base64_url_decoder_unit.sv
verif/tb_top.sv
